// ===== hw/rtl/page_first_fit_unit_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page first-fit allocator
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_FIRST_FIT_UNIT_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FIRST_FIT_UNIT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define PFFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pffa_pkg.sv =====
// ----------------------------------------------------------------------------
// pffa_pkg
// Types and constants shared by the page first-fit allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package pffa_pkg;

	localparam int PAGE_BYTES_DEF = 4096;
	// internal width of offsets, sizes and list links
	localparam int W       = 17;
	localparam int SIZE_W  = 13;
	localparam int OFF_W   = 11;
	localparam int FREE_W  = 12;
	localparam int WORD_W  = 16;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 32;

	typedef enum logic [0:0] {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DEC, S_WAIT, S_RESP,
		S_A_RD, S_A_CK, S_A_LK, S_A_PU,
		S_F_HM, S_F_HW, S_F_WALK, S_F_RM, S_F_RP, S_F_PU, S_F_BU
	} seq_state_t;

	typedef enum logic [2:0] {
		E_IDLE, E_R0, E_R1, E_W0, E_W1
	} blk_state_t;

	typedef struct packed {
		logic         valid;
		logic         wr;
		logic [W-1:0] addr;
		logic [W-1:0] size;
		logic [W-1:0] nxt;
	} blk_req_t;

	typedef struct packed {
		logic         done;
		logic [W-1:0] units;
		logic [W-1:0] nxt;
	} blk_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pffa_ram.sv =====
// ----------------------------------------------------------------------------
// pffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pffa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pffa_blk.sv =====
// ----------------------------------------------------------------------------
// pffa_blk
// Block header unit: reads or writes one free-block header in the page store.
// ----------------------------------------------------------------------------
`default_nettype none
module pffa_blk #(
	parameter int PU = 2048
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pffa_pkg::blk_req_t req,
	output pffa_pkg::blk_rsp_t      rsp
);
	import pffa_pkg::*;

	localparam int AW = $clog2(PU);
	localparam logic [W-1:0] PU_W = W'(PU);

	blk_state_t state_q, state_d;
	logic [W-1:0] addr_q, size_q, nxt_q, units_q, rnxt_q;
	logic         done_q, done_d;
	logic [W-1:0] addr1;
	logic              re, we;
	logic [AW-1:0]     raddr, waddr;
	logic [WORD_W-1:0] rdata, wdata;
	logic [W-1:0]      neg_nxt;

	assign addr1   = addr_q + W'(1);
	assign neg_nxt = W'(0) - nxt_q;

	pffa_ram #(.WIDTH(WORD_W), .DEPTH(PU)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: begin
				if (req.valid) begin
					if (req.wr) state_d = E_W0;
					else if (req.addr < PU_W) state_d = E_R0;
				end
			end
			E_R0: begin
				if (!rdata[WORD_W-1] && addr1 < PU_W) state_d = E_R1;
				else state_d = E_IDLE;
			end
			E_R1: state_d = E_IDLE;
			E_W0: begin
				if (size_q > W'(1)) state_d = E_W1;
				else state_d = E_IDLE;
			end
			E_W1: state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	// memory control and completion
	always_comb begin
		re     = 1'b0;
		we     = 1'b0;
		raddr  = addr_q[AW-1:0];
		waddr  = addr_q[AW-1:0];
		wdata  = size_q[WORD_W-1:0];
		done_d = 1'b0;
		unique case (state_q)
			E_IDLE: begin
				if (req.valid && !req.wr) begin
					if (req.addr < PU_W) begin
						re    = 1'b1;
						raddr = req.addr[AW-1:0];
					end else begin
						done_d = 1'b1;
					end
				end
			end
			E_R0: begin
				if (!rdata[WORD_W-1] && addr1 < PU_W) begin
					re    = 1'b1;
					raddr = addr1[AW-1:0];
				end else begin
					done_d = 1'b1;
				end
			end
			E_R1: done_d = 1'b1;
			E_W0: begin
				we = addr_q < PU_W;
				if (size_q <= W'(1)) begin
					wdata  = neg_nxt[WORD_W-1:0];
					done_d = 1'b1;
				end
			end
			E_W1: begin
				we     = addr1 < PU_W;
				waddr  = addr1[AW-1:0];
				wdata  = nxt_q[WORD_W-1:0];
				done_d = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// latch request, capture header fields
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && req.valid) begin
			addr_q <= req.addr;
			size_q <= req.size;
			nxt_q  <= req.nxt;
			if (!req.wr && req.addr >= PU_W) begin
				units_q <= W'(1);
				rnxt_q  <= '0;
			end
		end
		if (state_q == E_R0) begin
			if (rdata[WORD_W-1]) begin
				units_q <= W'(1);
				rnxt_q  <= W'(17'h10000) - W'(rdata);
			end else begin
				units_q <= (rdata == '0) ? W'(1) : W'(rdata);
				if (addr1 >= PU_W) rnxt_q <= '0;
			end
		end
		if (state_q == E_R1) begin
			rnxt_q <= W'(rdata);
		end
	end

	assign rsp.done  = done_q;
	assign rsp.units = units_q;
	assign rsp.nxt   = rnxt_q;
endmodule
`default_nettype wire

// ===== hw/rtl/page_first_fit_unit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// page_first_fit_unit_allocator_core
// First-fit allocator for one page of 2-byte units with an in-page free list.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                       | tuser
// s_      | in  | size_bytes[12:0], block_offset_in[23:13]  | kind[0]
// m_      | out | granted[0], block_offset_out[11:1],       | -
//         |     | page_released[12], free_units[24:13]      |
//
// One request at a time. Header reads and writes go through the shared header
// unit. An allocate is accepted and decoded, reads each free block visited and
// then splits or takes the fitting block and relinks; a free is accepted and
// decoded, reads the list head (unless the block goes in front of a head that it
// does not touch), then makes one header access per block walked and at most
// five to merge and relink. After reset the block writes the page header before
// s_tready rises; a free that empties the page does the same before its result.
// The result waits in the output register until m_tready.
// ----------------------------------------------------------------------------
`default_nettype none
module page_first_fit_unit_allocator_core #(
	parameter int PAGE_BYTES = pffa_pkg::PAGE_BYTES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [pffa_pkg::IN_W-1:0]  s_tdata,  // size_bytes, block_offset_in
	input  wire logic [0:0]                 s_tuser,  // kind
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [pffa_pkg::OUT_W-1:0]      m_tdata   // granted, offset, released, free
);
	import pffa_pkg::*;

	localparam int PU = PAGE_BYTES / 2;
	localparam int AW = $clog2(PU);
	localparam int LW = $clog2(PU + 1);
	localparam int CW = $clog2(PU + 2);
	localparam logic [W-1:0] PU_W = W'(PU);

	seq_state_t state_q, state_d, ret_q, ret_d;
	blk_req_t   req;
	blk_rsp_t   rsp;

	kind_t          kind_q;
	logic [W-1:0]   need_q, b_q, head_q, cur_q, prev_q, follow_q, size_q, pu_q;
	logic [LW-1:0]  left_q;
	logic [CW-1:0]  cnt_q;
	logic           has_prev_q, granted_q, rel_q;
	logic [OFF_W-1:0] where_q;

	logic [W-1:0] left_w, left_sum, b_end, need_in;
	logic alloc_bad, free_bad, free_rel, b_lt_head, head_merge;
	logic rsp_last, walk_go, fit, exact, tail_merge, prev_touch;

	pffa_blk #(.PU(PU)) u_blk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// request decode helpers
	assign need_in    = (W'(s_tdata[SIZE_W-1:0]) + W'(1)) >> 1;
	assign left_w     = W'(left_q);
	assign left_sum   = left_w + need_q;
	assign b_end      = b_q + need_q;
	assign alloc_bad  = (need_q == '0) || (need_q > left_w);
	assign free_bad   = (need_q == '0) || (b_end > PU_W) || (left_sum > PU_W);
	assign free_rel   = left_sum == PU_W;
	assign b_lt_head  = b_q < head_q;
	assign head_merge = (head_q < PU_W) && (b_end == head_q);
	assign rsp_last   = rsp.nxt[AW-1:0] == '0;
	assign walk_go    = (W'(cnt_q) <= PU_W) && (b_q > rsp.nxt);
	assign fit        = rsp.units >= need_q;
	assign exact      = rsp.units == need_q;
	assign tail_merge = !rsp_last && (b_end == rsp.nxt);
	assign prev_touch = (prev_q + rsp.units) == b_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: state_d = S_WAIT;
			S_IDLE: if (s_tvalid) state_d = S_DEC;
			S_DEC: begin
				if (kind_q == KIND_ALLOC) state_d = alloc_bad ? S_RESP : S_A_RD;
				else if (free_bad) state_d = S_RESP;
				else if (free_rel) state_d = S_INIT;
				else if (b_lt_head && !head_merge) state_d = S_F_HW;
				else state_d = S_WAIT;
			end
			S_WAIT: if (rsp.done) state_d = ret_q;
			S_RESP: if (m_tready) state_d = S_IDLE;
			S_A_RD: state_d = (cur_q >= PU_W) ? S_RESP : S_WAIT;
			S_A_CK: begin
				if (fit) state_d = exact ? S_A_LK : S_WAIT;
				else if (rsp_last || W'(cnt_q) == PU_W) state_d = S_RESP;
				else state_d = S_A_RD;
			end
			S_A_LK: state_d = has_prev_q ? S_WAIT : S_RESP;
			S_F_HM: state_d = S_F_HW;
			S_A_PU, S_F_HW, S_F_WALK, S_F_RM, S_F_RP, S_F_PU, S_F_BU: state_d = S_WAIT;
			default: state_d = S_IDLE;
		endcase
	end

	// header unit requests and return points
	always_comb begin
		req   = '0;
		ret_d = S_RESP;
		unique case (state_q)
			S_INIT: begin
				req   = '{valid: 1'b1, wr: 1'b1, addr: '0, size: PU_W, nxt: PU_W};
				ret_d = rel_q ? S_RESP : S_IDLE;
			end
			S_DEC: begin
				if (kind_q == KIND_FREE && !free_bad && !free_rel
				    && (!b_lt_head || head_merge)) begin
					req   = '{valid: 1'b1, wr: 1'b0, addr: head_q, size: '0, nxt: '0};
					ret_d = b_lt_head ? S_F_HM : S_F_WALK;
				end
			end
			S_A_RD: begin
				req   = '{valid: cur_q < PU_W, wr: 1'b0, addr: cur_q, size: '0, nxt: '0};
				ret_d = S_A_CK;
			end
			S_A_CK: begin
				req   = '{valid: fit && !exact, wr: 1'b1, addr: cur_q + need_q,
				          size: rsp.units - need_q, nxt: rsp.nxt};
				ret_d = S_A_LK;
			end
			S_A_LK: begin
				req   = '{valid: has_prev_q, wr: 1'b0, addr: prev_q, size: '0, nxt: '0};
				ret_d = S_A_PU;
			end
			S_A_PU: req = '{valid: 1'b1, wr: 1'b1, addr: prev_q, size: rsp.units,
			               nxt: follow_q};
			S_F_HW: req = '{valid: 1'b1, wr: 1'b1, addr: b_q, size: size_q, nxt: head_q};
			S_F_WALK: begin
				if (walk_go || tail_merge) begin
					req   = '{valid: 1'b1, wr: 1'b0, addr: rsp.nxt, size: '0, nxt: '0};
					ret_d = walk_go ? S_F_WALK : S_F_RM;
				end else begin
					req   = '{valid: 1'b1, wr: 1'b1, addr: b_q, size: size_q, nxt: rsp.nxt};
					ret_d = S_F_RP;
				end
			end
			S_F_RM: begin
				req   = '{valid: 1'b1, wr: 1'b1, addr: b_q, size: size_q + rsp.units,
				          nxt: rsp.nxt};
				ret_d = S_F_RP;
			end
			S_F_RP: begin
				req   = '{valid: 1'b1, wr: 1'b0, addr: prev_q, size: '0, nxt: '0};
				ret_d = S_F_PU;
			end
			S_F_PU: begin
				if (prev_touch) begin
					req   = '{valid: 1'b1, wr: 1'b0, addr: b_q, size: '0, nxt: '0};
					ret_d = S_F_BU;
				end else begin
					req = '{valid: 1'b1, wr: 1'b1, addr: prev_q, size: rsp.units, nxt: b_q};
				end
			end
			S_F_BU: req = '{valid: 1'b1, wr: 1'b1, addr: prev_q, size: rsp.units + pu_q,
			               nxt: rsp.nxt};
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q   <= S_IDLE;
			head_q  <= '0;
			left_q  <= LW'(PU);
			rel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.valid) ret_q <= ret_d;
			if (state_q == S_IDLE && s_tvalid) rel_q <= 1'b0;
			unique case (state_q)
				S_DEC: begin
					if (kind_q == KIND_FREE && !free_bad) begin
						if (free_rel) begin
							head_q <= '0;
							left_q <= LW'(PU);
							rel_q  <= 1'b1;
						end else begin
							left_q <= left_sum[LW-1:0];
						end
					end
				end
				S_A_CK: if (fit) left_q <= LW'(left_w - need_q);
				S_A_LK: if (!has_prev_q) head_q <= follow_q;
				S_F_HM: head_q <= rsp.nxt;
				S_F_HW: head_q <= b_q;
				default: ;
			endcase
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					kind_q    <= kind_t'(s_tuser[0]);
					need_q    <= need_in;
					b_q       <= W'(s_tdata[IN_W-1:SIZE_W]);
					granted_q <= 1'b0;
					where_q   <= '0;
				end
			end
			S_DEC: begin
				cur_q      <= head_q;
				prev_q     <= head_q;
				has_prev_q <= 1'b0;
				cnt_q      <= '0;
				size_q     <= need_q;
				if (kind_q == KIND_FREE && !free_bad) granted_q <= 1'b1;
			end
			S_A_CK: begin
				if (fit) begin
					granted_q <= 1'b1;
					where_q   <= cur_q[OFF_W-1:0];
					follow_q  <= exact ? rsp.nxt : cur_q + need_q;
				end else begin
					prev_q     <= cur_q;
					has_prev_q <= 1'b1;
					cur_q      <= rsp.nxt;
					cnt_q      <= cnt_q + CW'(1);
				end
			end
			S_F_HM: size_q <= size_q + rsp.units;
			S_F_WALK: begin
				if (walk_go) begin
					prev_q <= rsp.nxt;
					cnt_q  <= cnt_q + CW'(1);
				end
			end
			S_F_PU: pu_q <= rsp.units;
			default: ;
		endcase
	end

	// handshake and result packing
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = state_q == S_RESP;
	assign m_tdata  = {7'b0, left_w[FREE_W-1:0], rel_q, where_q, granted_q};
endmodule
`default_nettype wire

// ===== hw/rtl/pffa_chk.sv =====
// ----------------------------------------------------------------------------
// pffa_chk
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_first_fit_unit_allocator_core_macros.svh"
module pffa_chk #(
	parameter int PAGE_BYTES = pffa_pkg::PAGE_BYTES_DEF
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic [pffa_pkg::IN_W-1:0] s_tdata,
	input wire logic [0:0]                s_tuser,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [pffa_pkg::OUT_W-1:0] m_tdata
);
	localparam int PU = PAGE_BYTES / 2;
	localparam logic [11:0] PU_F = 12'(PU);
	logic unused_in;
	assign unused_in = ^{s_tdata, s_tuser};

	// one request in flight
	`PFFA_ASSERT_NXT(a_busy, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready after accept")
	`PFFA_ASSERT_IMP(a_excl, clk, arst_n, m_tvalid, !s_tready, "ready while result pending")
	// release resets the page
	`PFFA_ASSERT_IMP(a_rel, clk, arst_n, m_tvalid && m_tdata[12],
		m_tdata[0] && m_tdata[24:13] == PU_F, "release without full page")
	// refused requests carry no offset and no release
	`PFFA_ASSERT_IMP(a_fail, clk, arst_n, m_tvalid && !m_tdata[0],
		m_tdata[11:1] == 11'd0 && !m_tdata[12], "refusal with payload")
	`PFFA_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule

bind page_first_fit_unit_allocator_core pffa_chk #(.PAGE_BYTES(PAGE_BYTES)) u_pffa_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
